### design/ssci_pkg.sv
// ----------------------------------------------------------------------------
// ssci_pkg
// Shared constants, types and width helpers for the swept-sphere interval unit.
// ----------------------------------------------------------------------------
package ssci_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_WIDTH       = 31;
    localparam int CFG_IDX_W       = 1;
    localparam int MUL_CHUNK       = 32;
    localparam int MUL_LAT         = 5;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 31'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONTACT_DISTANCE = 1'b0,
        REG_HORIZON_TIME     = 1'b1
    } ssci_reg_t;

    // outcome of the front classification; neither bit set means solve the roots
    typedef struct packed {
        logic no_hit;
        logic unbounded;
    } ssci_class_t;

    // width of the dot-product sums a, h, p
    function automatic int sum_width(int cw);
        return 2 * cw + 4;
    endfunction

    // width of c = p - d*d
    function automatic int c_width(int cw);
        int ws;
        ws = sum_width(cw);
        return ((ws > 2 * CFG_WIDTH + 1) ? ws : 2 * CFG_WIDTH + 1) + 1;
    endfunction

    // width of the quarter discriminant h*h - a*c
    function automatic int disc_width(int cw);
        return 2 * c_width(cw);
    endfunction

endpackage

### design/ssci_if.sv
// ----------------------------------------------------------------------------
// ssci_if
// Valid/ready channels for body pairs and interval results.
// ----------------------------------------------------------------------------
interface ssci_pair_if
    import ssci_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_pos_x;
    logic signed [COORD_WIDTH-1:0] a_pos_y;
    logic signed [COORD_WIDTH-1:0] a_pos_z;
    logic signed [COORD_WIDTH-1:0] a_vel_x;
    logic signed [COORD_WIDTH-1:0] a_vel_y;
    logic signed [COORD_WIDTH-1:0] a_vel_z;
    logic signed [COORD_WIDTH-1:0] b_pos_x;
    logic signed [COORD_WIDTH-1:0] b_pos_y;
    logic signed [COORD_WIDTH-1:0] b_pos_z;
    logic signed [COORD_WIDTH-1:0] b_vel_x;
    logic signed [COORD_WIDTH-1:0] b_vel_y;
    logic signed [COORD_WIDTH-1:0] b_vel_z;

    modport source (
        output valid, a_pos_x, a_pos_y, a_pos_z, a_vel_x, a_vel_y, a_vel_z,
               b_pos_x, b_pos_y, b_pos_z, b_vel_x, b_vel_y, b_vel_z,
        input  ready
    );
    modport sink (
        input  valid, a_pos_x, a_pos_y, a_pos_z, a_vel_x, a_vel_y, a_vel_z,
               b_pos_x, b_pos_y, b_pos_z, b_vel_x, b_vel_y, b_vel_z,
        output ready
    );
endinterface

interface ssci_res_if
    import ssci_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          has_interval;
    logic signed [COORD_WIDTH-1:0] entry_time;
    logic signed [COORD_WIDTH-1:0] exit_time;
    logic                          exit_unbounded;
    logic signed [COORD_WIDTH-1:0] contact_time;
    logic                          will_collide;

    modport source (
        output valid, has_interval, entry_time, exit_time, exit_unbounded,
               contact_time, will_collide,
        input  ready
    );
    modport sink (
        input  valid, has_interval, entry_time, exit_time, exit_unbounded,
               contact_time, will_collide,
        output ready
    );
endinterface

### design/ssci_mul.sv
// ----------------------------------------------------------------------------
// ssci_mul
// Pipelined signed multiplier built from 32x32 partial products.
// ----------------------------------------------------------------------------
module ssci_mul
    import ssci_pkg::*;
#(
    parameter int W = 33
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   x,
    input  logic signed [W-1:0]   y,
    output logic signed [2*W-1:0] prod
);

    localparam int C  = MUL_CHUNK;
    localparam int K  = (W + C - 1) / C;
    localparam int WP = K * C;

    logic [W-1:0]     xa;
    logic [W-1:0]     ya;
    logic [WP-1:0]    xm_reg;
    logic [WP-1:0]    ym_reg;
    logic [3:0]       sg_reg;
    logic [2*C-1:0]   pp_reg [K][K];
    logic [2*WP-1:0]  row_next [K];
    logic [2*WP-1:0]  row_reg [K];
    logic [2*WP-1:0]  tot_next;
    logic [2*WP-1:0]  tot_reg;
    logic [2*W-1:0]   prod_reg;

    assign xa = x[W-1] ? (~x + 1'b1) : x;
    assign ya = y[W-1] ? (~y + 1'b1) : y;

    always_comb
    begin
        for (int i = 0; i < K; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < K; j++)
            begin
                row_next[i] = row_next[i] + ((2 * WP)'(pp_reg[i][j]) << (C * j));
            end
        end
        tot_next = '0;
        for (int i = 0; i < K; i++)
        begin
            tot_next = tot_next + (row_reg[i] << (C * i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xm_reg <= WP'(xa);
            ym_reg <= WP'(ya);
            sg_reg <= {sg_reg[2:0], x[W-1] ^ y[W-1]};
            for (int i = 0; i < K; i++)
            begin
                for (int j = 0; j < K; j++)
                begin
                    pp_reg[i][j] <= (2 * C)'(xm_reg[i*C +: C]) * (2 * C)'(ym_reg[j*C +: C]);
                end
                row_reg[i] <= row_next[i];
            end
            tot_reg  <= tot_next;
            prod_reg <= sg_reg[3] ? (~tot_reg[2*W-1:0] + 1'b1) : tot_reg[2*W-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

### design/ssci_front.sv
// ----------------------------------------------------------------------------
// ssci_front
// Accepts body pairs, forms a, h, c and the discriminant, classifies each pair.
// ----------------------------------------------------------------------------
module ssci_front
    import ssci_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    ssci_pair_if.sink                              pair_ch,
    input  logic [CFG_WIDTH-1:0]                   contact_distance,
    input  logic                                   q_full,
    output logic                                   push,
    output ssci_class_t                            push_class,
    output logic [disc_width(COORD_WIDTH)-1:0]     push_d,
    output logic [sum_width(COORD_WIDTH)-1:0]      push_h,
    output logic [sum_width(COORD_WIDTH)-1:0]      push_a
);

    localparam int CW   = COORD_WIDTH;
    localparam int WR   = CW + 1;
    localparam int WS   = sum_width(CW);
    localparam int WC   = c_width(CW);
    localparam int WD   = disc_width(CW);
    localparam int NSTG = 2 * MUL_LAT + 4;
    localparam longint unsigned EPS_RAW = (64'd1 << (2 * FRAC_BITS)) / 10000;
    localparam logic signed [WC-1:0] EPS_C = WC'(EPS_RAW);

    logic                   adv;
    logic [NSTG-1:0]        v_reg;
    logic signed [WR-1:0]   rp_reg [3];
    logic signed [WR-1:0]   rv_reg [3];
    logic signed [31:0]     dist_reg;
    logic signed [2*WR-1:0] vv [3];
    logic signed [2*WR-1:0] pv [3];
    logic signed [2*WR-1:0] pp [3];
    logic signed [63:0]     dd;
    logic signed [WS-1:0]   a_s_reg;
    logic signed [WS-1:0]   h_s_reg;
    logic signed [WS-1:0]   p_s_reg;
    logic signed [63:0]     dd_s_reg;
    logic signed [WS-1:0]   a_c_reg;
    logic signed [WS-1:0]   h_c_reg;
    logic signed [WC-1:0]   c_c_reg;
    logic signed [WC-1:0]   a_cx;
    logic signed [2*WS-1:0] hh;
    logic signed [WD-1:0]   ac;
    logic signed [WS-1:0]   a_dl_reg [MUL_LAT];
    logic signed [WS-1:0]   h_dl_reg [MUL_LAT];
    logic signed [WC-1:0]   c_dl_reg [MUL_LAT];
    logic signed [WD-1:0]   d_next;
    logic                   no_root;
    logic                   c_big;
    logic [WD-1:0]          d_reg;
    logic [WS-1:0]          a_o_reg;
    logic [WS-1:0]          h_o_reg;
    ssci_class_t            cls_reg;

    // the last stage drains into the queue; hold everything while it is valid and the queue is full
    assign adv           = !v_reg[NSTG-1] || !q_full;
    assign pair_ch.ready = adv;
    assign push          = v_reg[NSTG-1] && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NSTG-2:0], pair_ch.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rp_reg[0] <= {pair_ch.a_pos_x[CW-1], pair_ch.a_pos_x}
                       - {pair_ch.b_pos_x[CW-1], pair_ch.b_pos_x};
            rp_reg[1] <= {pair_ch.a_pos_y[CW-1], pair_ch.a_pos_y}
                       - {pair_ch.b_pos_y[CW-1], pair_ch.b_pos_y};
            rp_reg[2] <= {pair_ch.a_pos_z[CW-1], pair_ch.a_pos_z}
                       - {pair_ch.b_pos_z[CW-1], pair_ch.b_pos_z};
            rv_reg[0] <= {pair_ch.a_vel_x[CW-1], pair_ch.a_vel_x}
                       - {pair_ch.b_vel_x[CW-1], pair_ch.b_vel_x};
            rv_reg[1] <= {pair_ch.a_vel_y[CW-1], pair_ch.a_vel_y}
                       - {pair_ch.b_vel_y[CW-1], pair_ch.b_vel_y};
            rv_reg[2] <= {pair_ch.a_vel_z[CW-1], pair_ch.a_vel_z}
                       - {pair_ch.b_vel_z[CW-1], pair_ch.b_vel_z};
            dist_reg  <= {1'b0, contact_distance};
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        ssci_mul #(.W(WR)) u_vv (.clk(clk), .en(adv), .x(rv_reg[i]), .y(rv_reg[i]), .prod(vv[i]));
        ssci_mul #(.W(WR)) u_pv (.clk(clk), .en(adv), .x(rp_reg[i]), .y(rv_reg[i]), .prod(pv[i]));
        ssci_mul #(.W(WR)) u_pp (.clk(clk), .en(adv), .x(rp_reg[i]), .y(rp_reg[i]), .prod(pp[i]));
    end

    ssci_mul #(.W(32)) u_dd (.clk(clk), .en(adv), .x(dist_reg), .y(dist_reg), .prod(dd));

    assign a_cx = WC'(a_c_reg);

    ssci_mul #(.W(WS)) u_hh (.clk(clk), .en(adv), .x(h_c_reg), .y(h_c_reg), .prod(hh));
    ssci_mul #(.W(WC)) u_ac (.clk(clk), .en(adv), .x(a_cx), .y(c_c_reg), .prod(ac));

    assign d_next  = WD'(hh) - ac;
    assign no_root = (a_dl_reg[MUL_LAT-1] == '0) || d_next[WD-1];
    assign c_big   = c_dl_reg[MUL_LAT-1] > EPS_C;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_s_reg  <= WS'(vv[0]) + WS'(vv[1]) + WS'(vv[2]);
            h_s_reg  <= WS'(pv[0]) + WS'(pv[1]) + WS'(pv[2]);
            p_s_reg  <= WS'(pp[0]) + WS'(pp[1]) + WS'(pp[2]);
            dd_s_reg <= dd;
            a_c_reg  <= a_s_reg;
            h_c_reg  <= h_s_reg;
            c_c_reg  <= WC'(p_s_reg) - WC'(dd_s_reg);
            a_dl_reg[0] <= a_c_reg;
            h_dl_reg[0] <= h_c_reg;
            c_dl_reg[0] <= c_c_reg;
            for (int i = 1; i < MUL_LAT; i++)
            begin
                a_dl_reg[i] <= a_dl_reg[i-1];
                h_dl_reg[i] <= h_dl_reg[i-1];
                c_dl_reg[i] <= c_dl_reg[i-1];
            end
            d_reg             <= d_next;
            a_o_reg           <= a_dl_reg[MUL_LAT-1];
            h_o_reg           <= h_dl_reg[MUL_LAT-1];
            cls_reg.no_hit    <= no_root && c_big;
            cls_reg.unbounded <= no_root && !c_big;
        end
    end

    assign push_class = cls_reg;
    assign push_d     = d_reg;
    assign push_h     = h_o_reg;
    assign push_a     = a_o_reg;

endmodule

### design/ssci_queue.sv
// ----------------------------------------------------------------------------
// ssci_queue
// Short FIFO between the classifying front and the solving back.
// ----------------------------------------------------------------------------
module ssci_queue
    import ssci_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [NW-1:0] count_reg;
    logic [PW-1:0] wr_next;
    logic [PW-1:0] rd_next;

    assign wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
    assign rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
    assign full    = count_reg == NW'(DEPTH);
    assign empty   = count_reg == '0;
    assign rdata   = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_next;
            end
            if (pop)
            begin
                rd_reg <= rd_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("queue count out of range");
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !empty)
        else $error("pushed beat lost");

endmodule

### design/ssci_back.sv
// ----------------------------------------------------------------------------
// ssci_back
// Pipelined square root and dividers for the roots, then contact and horizon.
// ----------------------------------------------------------------------------
module ssci_back
    import ssci_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  ssci_class_t                        q_class,
    input  logic [disc_width(COORD_WIDTH)-1:0] q_d,
    input  logic [sum_width(COORD_WIDTH)-1:0]  q_h,
    input  logic [sum_width(COORD_WIDTH)-1:0]  q_a,
    output logic                               pop,
    input  logic [CFG_WIDTH-1:0]               horizon_time,
    ssci_res_if.source                         res_ch
);

    localparam int CW   = COORD_WIDTH;
    localparam int WS   = sum_width(CW);
    localparam int WC   = c_width(CW);
    localparam int WD   = disc_width(CW);
    localparam int SQ   = WC;
    localparam int RW   = SQ + 2;
    localparam int WN   = WC + 2;
    localparam int WM   = WN + FRAC_BITS;
    localparam int WX   = (WM > WS + CW) ? WM : WS + CW;
    localparam int NB   = SQ + CW + 4;
    localparam int CMPW = ((CW > CFG_WIDTH) ? CW : CFG_WIDTH) + 1;
    localparam logic [CW-1:0] T_MAX   = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-1:0] T_MIN   = {1'b1, {(CW - 1){1'b0}}};
    localparam logic [CW-1:0] ONE_FX  = CW'(1) << FRAC_BITS;
    localparam logic [CW-1:0] NEG_ONE = ~ONE_FX + CW'(1);

    logic              adv;
    logic [NB-1:0]     bv_reg;
    logic              ov_reg;

    // square root stages
    ssci_class_t       scls_reg  [SQ+1];
    logic [WS-1:0]     sa_reg    [SQ+1];
    logic [WS-1:0]     sh_reg    [SQ+1];
    logic [WD-1:0]     srad_reg  [SQ+1];
    logic [RW-1:0]     srem_reg  [SQ+1];
    logic [SQ-1:0]     sroot_reg [SQ+1];

    // root numerators
    ssci_class_t       p1_cls_reg;
    logic [WS-1:0]     p1_a_reg;
    logic signed [WN-1:0] p1_lo_reg;
    logic signed [WN-1:0] p1_hi_reg;
    logic signed [WN-1:0] h_x;
    logic signed [WN-1:0] s_x;
    logic [WN-1:0]     lo_mag;
    logic [WN-1:0]     hi_mag;

    // divider stages
    ssci_class_t       dcls_reg [CW+1];
    logic [WS-1:0]     da_reg   [CW+1];
    logic [WX-1:0]     drl_reg  [CW+1];
    logic [WX-1:0]     drh_reg  [CW+1];
    logic              dnl_reg  [CW+1];
    logic              dnh_reg  [CW+1];
    logic [CW-1:0]     dql_reg  [CW+1];
    logic [CW-1:0]     dqh_reg  [CW+1];
    logic              dsl_reg  [CW+1];
    logic              dsh_reg  [CW+1];

    // final stages
    logic              f_has_reg;
    logic              f_unb_reg;
    logic [CW-1:0]     f_entry_reg;
    logic [CW-1:0]     f_exit_reg;
    logic [CMPW-1:0]   t_cmp;
    logic              o_has_reg;
    logic              o_unb_reg;
    logic              o_coll_reg;
    logic [CW-1:0]     o_entry_reg;
    logic [CW-1:0]     o_exit_reg;
    logic [CW-1:0]     o_contact_reg;

    function automatic logic [CW-1:0] fix_root(input logic sat, input logic neg,
                                               input logic [CW-1:0] q, input logic rnz);
        logic [CW-1:0] r;
        if (sat)
        begin
            r = neg ? T_MIN : T_MAX;
        end
        else if (neg)
        begin
            r = ~(q + CW'(rnz)) + CW'(1);
        end
        else
        begin
            r = q;
        end
        return r;
    endfunction

    assign adv = !ov_reg || res_ch.ready;
    assign pop = adv && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg <= '0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            bv_reg <= {bv_reg[NB-2:0], !q_empty};
            ov_reg <= bv_reg[NB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scls_reg[0]  <= q_class;
            sa_reg[0]    <= q_a;
            sh_reg[0]    <= q_h;
            srad_reg[0]  <= q_d;
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
        end
    end

    // one root bit per stage, two radicand bits consumed each time
    for (genvar k = 1; k <= SQ; k++)
    begin : g_sqrt
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          ge;

        assign rem_sh = {srem_reg[k-1][RW-3:0], srad_reg[k-1][WD-1 -: 2]};
        assign trial  = {sroot_reg[k-1], 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                srem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
                sroot_reg[k] <= {sroot_reg[k-1][SQ-2:0], ge};
                srad_reg[k]  <= {srad_reg[k-1][WD-3:0], 2'b00};
                scls_reg[k]  <= scls_reg[k-1];
                sa_reg[k]    <= sa_reg[k-1];
                sh_reg[k]    <= sh_reg[k-1];
            end
        end
    end

    assign h_x    = {{(WN - WS){sh_reg[SQ][WS-1]}}, sh_reg[SQ]};
    assign s_x    = {{(WN - SQ){1'b0}}, sroot_reg[SQ]};
    assign lo_mag = p1_lo_reg[WN-1] ? (~p1_lo_reg + 1'b1) : p1_lo_reg;
    assign hi_mag = p1_hi_reg[WN-1] ? (~p1_hi_reg + 1'b1) : p1_hi_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_cls_reg  <= scls_reg[SQ];
            p1_a_reg    <= sa_reg[SQ];
            p1_lo_reg   <= -h_x - s_x;
            p1_hi_reg   <= s_x - h_x;
            dcls_reg[0] <= p1_cls_reg;
            da_reg[0]   <= p1_a_reg;
            drl_reg[0]  <= WX'(lo_mag) << FRAC_BITS;
            drh_reg[0]  <= WX'(hi_mag) << FRAC_BITS;
            dnl_reg[0]  <= p1_lo_reg[WN-1];
            dnh_reg[0]  <= p1_hi_reg[WN-1];
            dql_reg[0]  <= '0;
            dqh_reg[0]  <= '0;
            dsl_reg[0]  <= 1'b0;
            dsh_reg[0]  <= 1'b0;
        end
    end

    // restoring division, MSB first; a hit on the top bit means saturation
    for (genvar j = 1; j <= CW; j++)
    begin : g_div
        localparam int K = CW - j;
        logic [WX-1:0] dvs;
        logic          ge_l;
        logic          ge_h;

        assign dvs  = WX'(da_reg[j-1]) << K;
        assign ge_l = drl_reg[j-1] >= dvs;
        assign ge_h = drh_reg[j-1] >= dvs;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                drl_reg[j]  <= ge_l ? drl_reg[j-1] - dvs : drl_reg[j-1];
                drh_reg[j]  <= ge_h ? drh_reg[j-1] - dvs : drh_reg[j-1];
                dql_reg[j]  <= {dql_reg[j-1][CW-2:0], ge_l};
                dqh_reg[j]  <= {dqh_reg[j-1][CW-2:0], ge_h};
                dsl_reg[j]  <= (j == 1) ? ge_l : dsl_reg[j-1];
                dsh_reg[j]  <= (j == 1) ? ge_h : dsh_reg[j-1];
                dnl_reg[j]  <= dnl_reg[j-1];
                dnh_reg[j]  <= dnh_reg[j-1];
                dcls_reg[j] <= dcls_reg[j-1];
                da_reg[j]   <= da_reg[j-1];
            end
        end
    end

    assign t_cmp = f_entry_reg[CW-1] ? '0 : CMPW'(f_entry_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dcls_reg[CW].no_hit)
            begin
                f_has_reg   <= 1'b0;
                f_unb_reg   <= 1'b0;
                f_entry_reg <= '0;
                f_exit_reg  <= '0;
            end
            else if (dcls_reg[CW].unbounded)
            begin
                f_has_reg   <= 1'b1;
                f_unb_reg   <= 1'b1;
                f_entry_reg <= '0;
                f_exit_reg  <= T_MAX;
            end
            else
            begin
                f_has_reg   <= 1'b1;
                f_unb_reg   <= 1'b0;
                f_entry_reg <= fix_root(dsl_reg[CW], dnl_reg[CW], dql_reg[CW],
                                        drl_reg[CW] != '0);
                f_exit_reg  <= fix_root(dsh_reg[CW], dnh_reg[CW], dqh_reg[CW],
                                        drh_reg[CW] != '0);
            end

            o_has_reg   <= f_has_reg;
            o_unb_reg   <= f_unb_reg;
            o_entry_reg <= f_entry_reg;
            o_exit_reg  <= f_exit_reg;
            if (!f_has_reg)
            begin
                o_contact_reg <= NEG_ONE;
            end
            else if (f_exit_reg[CW-1])
            begin
                o_contact_reg <= f_exit_reg;
            end
            else if (f_entry_reg[CW-1])
            begin
                o_contact_reg <= '0;
            end
            else
            begin
                o_contact_reg <= f_entry_reg;
            end
            o_coll_reg <= f_has_reg && !f_exit_reg[CW-1]
                       && (t_cmp <= CMPW'(horizon_time));
        end
    end

    assign res_ch.valid          = ov_reg;
    assign res_ch.has_interval   = o_has_reg;
    assign res_ch.entry_time     = o_entry_reg;
    assign res_ch.exit_time      = o_exit_reg;
    assign res_ch.exit_unbounded = o_unb_reg;
    assign res_ch.contact_time   = o_contact_reg;
    assign res_ch.will_collide   = o_coll_reg;

endmodule

### design/swept_sphere_collision_interval_unit.sv
// ----------------------------------------------------------------------------
// swept_sphere_collision_interval_unit
// Entry, exit and first contact time of two linearly moving spheres.
//
//   channel   dir   handshake             payload
//   pair_ch   in    valid/ready           positions and velocities of A and B
//   res_ch    out   valid/ready           interval, contact time, collide flag
//   cfg       in    cfg_we, no wait       cfg_index, cfg_wdata (31 bits)
//
// One pair per cycle sustained while res_ch is ready; every stage is pipelined.
// The back is built from one-bit-per-stage square root and divider chains.
// The front stalls only when the queue is full; the back stalls only while
// a finished result waits on res_ch.
// Reset clears the valid bits and queue pointers at once; no clearing pass.
// ----------------------------------------------------------------------------
module swept_sphere_collision_interval_unit
    import ssci_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ssci_pair_if.sink            pair_ch,
    ssci_res_if.source           res_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_wdata
);

    localparam int WS = sum_width(COORD_WIDTH);
    localparam int WD = disc_width(COORD_WIDTH);
    localparam int QW = $bits(ssci_class_t) + WD + 2 * WS;

    logic [CFG_WIDTH-1:0] contact_distance_reg;
    logic [CFG_WIDTH-1:0] horizon_time_reg;

    logic                 push;
    ssci_class_t          push_class;
    logic [WD-1:0]        push_d;
    logic [WS-1:0]        push_h;
    logic [WS-1:0]        push_a;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;
    logic [QW-1:0]        q_rdata;
    ssci_class_t          q_class;
    logic [WD-1:0]        q_d;
    logic [WS-1:0]        q_h;
    logic [WS-1:0]        q_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contact_distance_reg <= CFG_RESET;
            horizon_time_reg     <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CONTACT_DISTANCE: contact_distance_reg <= cfg_wdata;
                REG_HORIZON_TIME:     horizon_time_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ssci_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .pair_ch          (pair_ch),
        .contact_distance (contact_distance_reg),
        .q_full           (q_full),
        .push             (push),
        .push_class       (push_class),
        .push_d           (push_d),
        .push_h           (push_h),
        .push_a           (push_a)
    );

    ssci_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({push_class, push_d, push_h, push_a}),
        .pop   (pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign {q_class, q_d, q_h, q_a} = q_rdata;

    ssci_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_class      (q_class),
        .q_d          (q_d),
        .q_h          (q_h),
        .q_a          (q_a),
        .pop          (pop),
        .horizon_time (horizon_time_reg),
        .res_ch       (res_ch)
    );

endmodule
